// ----- hdl/cfpst_pkg.sv -----
// ----------------------------------------------------------------------------
// Coarse/fine power setpoint tracker package
// Shared widths, register indexes, reset values and types.
// ----------------------------------------------------------------------------
package cfpst_pkg;

  // Converter sample width (8..16).
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned PROD_W      = 2 * SAMPLE_BITS;

  localparam int unsigned POWER_W   = 8;
  localparam int unsigned STEP_W    = 8;
  localparam int unsigned ACC_W     = 16;
  localparam int unsigned DUTY_W    = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  // power = product / 100, saturated at 255.
  // Products of at least 256 * 100 saturate; below that a reciprocal
  // multiply (x * 5243) >> 19 gives the exact floor for x < 25600.
  localparam int unsigned POWER_MAX         = 255;
  localparam int unsigned POWER_DIVISOR     = 100;
  localparam int unsigned POWER_SAT_PRODUCT = (POWER_MAX + 1) * POWER_DIVISOR;
  localparam int unsigned QUOT_IN_W         = 15;
  localparam int unsigned RECIP_MULT        = 5243;
  localparam int unsigned RECIP_W           = 13;
  localparam int unsigned RECIP_SHIFT       = 19;
  localparam int unsigned RECIP_FULL_W      = QUOT_IN_W + RECIP_W;

  localparam int unsigned DUTY_MAX = 900;

  typedef logic [SAMPLE_BITS-1:0]  sample_t;
  typedef logic [PROD_W-1:0]       prod_t;
  typedef logic [RECIP_FULL_W-1:0] recip_t;
  typedef logic [POWER_W-1:0]      power_t;
  typedef logic [STEP_W-1:0]       step_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [DUTY_W-1:0]       duty_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER_SETPOINT    = 3'd0,
    REG_OVERRIDE_SETPOINT = 3'd1,
    REG_OVERRIDE_ENABLE   = 3'd2,
    REG_COARSE_STEP       = 3'd3,
    REG_FINE_STEP         = 3'd4,
    REG_COARSE_BAND       = 3'd5,
    REG_FINE_BAND         = 3'd6
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam power_t RST_POWER_SETPOINT    = 8'd255;
  localparam power_t RST_OVERRIDE_SETPOINT = 8'd0;
  localparam logic   RST_OVERRIDE_ENABLE   = 1'b0;
  localparam step_t  RST_COARSE_STEP       = 8'd50;
  localparam step_t  RST_FINE_STEP         = 8'd2;
  localparam power_t RST_COARSE_BAND       = 8'd50;
  localparam power_t RST_FINE_BAND         = 8'd5;

  typedef enum logic {
    MODE_COARSE = 1'b0,
    MODE_FINE   = 1'b1
  } mode_t;

  typedef struct packed {
    power_t power_setpoint;
    power_t override_setpoint;
    logic   override_enable;
    step_t  coarse_step;
    step_t  fine_step;
    power_t coarse_band;
    power_t fine_band;
  } cfg_t;

endpackage

// ----- hdl/cfpst_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration register file
// Seven tracker registers written over a valid/ready port; unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module cfpst_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cfpst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfpst_pkg::CFG_DAT_W-1:0]      cfg_data,
  output cfpst_pkg::cfg_t                      cfg
);

  cfpst_pkg::cfg_t cfg_r;
  cfpst_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfpst_pkg::cfg_reg_t'(cfg_index))
        cfpst_pkg::REG_POWER_SETPOINT:    cfg_nxt.power_setpoint    = cfg_data;
        cfpst_pkg::REG_OVERRIDE_SETPOINT: cfg_nxt.override_setpoint = cfg_data;
        cfpst_pkg::REG_OVERRIDE_ENABLE:   cfg_nxt.override_enable   = cfg_data[0];
        cfpst_pkg::REG_COARSE_STEP:       cfg_nxt.coarse_step       = cfg_data;
        cfpst_pkg::REG_FINE_STEP:         cfg_nxt.fine_step         = cfg_data;
        cfpst_pkg::REG_COARSE_BAND:       cfg_nxt.coarse_band       = cfg_data;
        cfpst_pkg::REG_FINE_BAND:         cfg_nxt.fine_band         = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_setpoint    <= cfpst_pkg::RST_POWER_SETPOINT;
      cfg_r.override_setpoint <= cfpst_pkg::RST_OVERRIDE_SETPOINT;
      cfg_r.override_enable   <= cfpst_pkg::RST_OVERRIDE_ENABLE;
      cfg_r.coarse_step       <= cfpst_pkg::RST_COARSE_STEP;
      cfg_r.fine_step         <= cfpst_pkg::RST_FINE_STEP;
      cfg_r.coarse_band       <= cfpst_pkg::RST_COARSE_BAND;
      cfg_r.fine_band         <= cfpst_pkg::RST_FINE_BAND;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/cfpst_power.sv -----
// ----------------------------------------------------------------------------
// Power computation pipeline
// Input register, voltage x current product register, then divide by 100
// through a reciprocal multiply with saturation to 8 bits.
// ----------------------------------------------------------------------------
module cfpst_power (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cfpst_pkg::sample_t    in_voltage,
  input  cfpst_pkg::sample_t    in_current,
  output logic                  pw_valid,
  input  logic                  pw_ready,
  output cfpst_pkg::power_t     pw_power
);

  logic               s1_valid_r, s2_valid_r, s3_valid_r;
  logic               s1_ready, s2_ready, s3_ready;
  cfpst_pkg::sample_t volt_r, curr_r;
  cfpst_pkg::prod_t   prod_r;
  cfpst_pkg::power_t  power_r;
  cfpst_pkg::recip_t  recip_full;
  cfpst_pkg::power_t  power_nxt;

  // Each stage moves when it is empty or the one after it moves.
  assign s3_ready = !s3_valid_r || pw_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    recip_full = cfpst_pkg::recip_t'(prod_r[cfpst_pkg::QUOT_IN_W-1:0])
               * cfpst_pkg::recip_t'(cfpst_pkg::RECIP_MULT);
    if (prod_r >= cfpst_pkg::prod_t'(cfpst_pkg::POWER_SAT_PRODUCT)) begin
      power_nxt = cfpst_pkg::power_t'(cfpst_pkg::POWER_MAX);
    end else begin
      power_nxt = recip_full[cfpst_pkg::RECIP_SHIFT +: cfpst_pkg::POWER_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      volt_r <= in_voltage;
      curr_r <= in_current;
    end
    if (s1_valid_r && s2_ready) begin
      prod_r <= cfpst_pkg::prod_t'(volt_r) * cfpst_pkg::prod_t'(curr_r);
    end
    if (s2_valid_r && s3_ready) begin
      power_r <= power_nxt;
    end
  end

  assign pw_valid = s3_valid_r;
  assign pw_power = power_r;

endmodule

// ----- hdl/cfpst_track.sv -----
// ----------------------------------------------------------------------------
// Coarse/fine tracker and result register
// Compare power with the active setpoint, pick the step mode, move the
// saturating duty accumulator and register the result item.
// ----------------------------------------------------------------------------
module cfpst_track (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfpst_pkg::cfg_t        cfg,
  input  logic                   pw_valid,
  output logic                   pw_ready,
  input  cfpst_pkg::power_t      pw_power,
  output logic                   out_valid,
  input  logic                   out_stall,
  output cfpst_pkg::duty_t       out_duty_permille,
  output cfpst_pkg::power_t      out_measured_power,
  output logic                   out_fine_mode,
  output logic                   out_on_target
);

  cfpst_pkg::mode_t   mode_r, mode_nxt;
  logic               hold_r, hold_nxt;
  cfpst_pkg::acc_t    acc_r, acc_nxt;

  logic               out_valid_r;
  cfpst_pkg::duty_t   duty_r, duty_nxt;
  cfpst_pkg::power_t  power_r;
  logic               fine_r;
  logic               on_target_r, on_target_nxt;

  logic               load;
  cfpst_pkg::power_t  setpoint;
  logic               up;
  cfpst_pkg::power_t  err;
  logic               do_step;
  cfpst_pkg::step_t   step;
  logic [cfpst_pkg::ACC_W:0] sum;

  assign pw_ready = !out_valid_r || !out_stall;
  assign load     = pw_valid && pw_ready;

  always_comb begin
    setpoint = cfg.override_enable ? cfg.override_setpoint : cfg.power_setpoint;
    up       = pw_power > setpoint;
    err      = up ? (pw_power - setpoint) : (setpoint - pw_power);

    mode_nxt      = mode_r;
    hold_nxt      = hold_r;
    on_target_nxt = 1'b0;
    do_step       = 1'b1;
    step          = cfg.fine_step;

    if (hold_r) begin
      // follow-up to a hold: fine step, no mode check
      hold_nxt = 1'b0;
    end else if (mode_r == cfpst_pkg::MODE_COARSE) begin
      if (err < cfg.coarse_band) begin
        mode_nxt = cfpst_pkg::MODE_FINE;
      end else begin
        step = cfg.coarse_step;
      end
    end else begin
      if (err > cfg.coarse_band) begin
        mode_nxt = cfpst_pkg::MODE_COARSE;
        step     = cfg.coarse_step;
      end else if (err <= cfg.fine_band) begin
        do_step       = 1'b0;
        hold_nxt      = 1'b1;
        on_target_nxt = 1'b1;
      end
    end

    // saturating accumulate in one extra bit
    if (up) begin
      sum = {acc_r[cfpst_pkg::ACC_W-1], acc_r}
          + {{(cfpst_pkg::ACC_W + 1 - cfpst_pkg::STEP_W){1'b0}}, step};
    end else begin
      sum = {acc_r[cfpst_pkg::ACC_W-1], acc_r}
          - {{(cfpst_pkg::ACC_W + 1 - cfpst_pkg::STEP_W){1'b0}}, step};
    end

    if (!do_step) begin
      acc_nxt = acc_r;
    end else if (sum[cfpst_pkg::ACC_W] != sum[cfpst_pkg::ACC_W-1]) begin
      acc_nxt = sum[cfpst_pkg::ACC_W]
              ? {1'b1, {(cfpst_pkg::ACC_W-1){1'b0}}}
              : {1'b0, {(cfpst_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_nxt = sum[cfpst_pkg::ACC_W-1:0];
    end

    // clamp to 0..900
    if (acc_nxt < cfpst_pkg::acc_t'(1)) begin
      duty_nxt = '0;
    end else if (acc_nxt > cfpst_pkg::acc_t'(cfpst_pkg::DUTY_MAX)) begin
      duty_nxt = cfpst_pkg::duty_t'(cfpst_pkg::DUTY_MAX);
    end else begin
      duty_nxt = acc_nxt[cfpst_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= cfpst_pkg::MODE_COARSE;
      hold_r      <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pw_ready) out_valid_r <= pw_valid;
      if (load) begin
        mode_r <= mode_nxt;
        hold_r <= hold_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      duty_r      <= duty_nxt;
      power_r     <= pw_power;
      fine_r      <= (mode_nxt == cfpst_pkg::MODE_FINE);
      on_target_r <= on_target_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_duty_permille  = duty_r;
  assign out_measured_power = power_r;
  assign out_fine_mode      = fine_r;
  assign out_on_target      = on_target_r;

  // A hold is only ever pending in fine mode.
  a_hold_in_fine: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r |-> (mode_r == cfpst_pkg::MODE_FINE))
    else $error("hold pending outside fine mode");

  // The item that follows a hold never reports on target.
  a_no_double_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (load && hold_r) |=> !out_on_target)
    else $error("on target reported on hold follow-up");

  // A hold leaves the accumulator untouched.
  a_hold_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (load && on_target_nxt) |=> $stable(acc_r))
    else $error("accumulator moved during hold");

  // On target implies fine mode in the same result.
  a_on_target_fine: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && on_target_r) |-> fine_r)
    else $error("on target outside fine mode");

endmodule

// ----- hdl/coarse_fine_power_setpoint_tracker.sv -----
// ----------------------------------------------------------------------------
// Coarse/fine power setpoint tracker
// Two-step-size perturb and observe duty tracker for a power converter.
// ----------------------------------------------------------------------------
// Each item carries one voltage and one current reading. Power is
// voltage * current / 100, truncated and saturated at 255, and is compared
// with the active setpoint (override_setpoint when override_enable is set,
// else power_setpoint). The tracker runs in coarse or fine step mode and
// moves a signed, saturating 16-bit duty accumulator up by the mode's step
// when power is above the setpoint and down otherwise; in fine mode an
// error within fine_band holds the duty for one item and flags on_target,
// and the next item takes a fine step with no mode check. Duty is reported
// in permille, 0 below 1 and clamped at 900. The block takes one item per
// clock cycle while the result side does not stall; the product, power and
// result registers follow the input register. The product and the
// reciprocal divide by 100 are pipelined, and the tracker update at the
// result register carries the state from item to item. A stall on the
// result side backs up only through full stages, so empty stages keep
// taking items. Configuration writes are always ready and take effect on
// the next cycle; write them only while the block is idle.
// ----------------------------------------------------------------------------
module coarse_fine_power_setpoint_tracker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [cfpst_pkg::SAMPLE_BITS-1:0]     in_voltage_sample,
  input  logic [cfpst_pkg::SAMPLE_BITS-1:0]     in_current_sample,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [cfpst_pkg::DUTY_W-1:0]          out_duty_permille,
  output logic [cfpst_pkg::POWER_W-1:0]         out_measured_power,
  output logic                                  out_fine_mode,
  output logic                                  out_on_target,
  // configuration write port
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cfpst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cfpst_pkg::CFG_DAT_W-1:0]       cfg_data
);

  cfpst_pkg::cfg_t   cfg;
  logic              in_ready;
  logic              pw_valid;
  logic              pw_ready;
  cfpst_pkg::power_t pw_power;

  // Register file: always ready, unknown indexes dropped.
  cfpst_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Power pipeline: hold the sample, multiply, divide and saturate.
  cfpst_power u_power (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_voltage (in_voltage_sample),
    .in_current (in_current_sample),
    .pw_valid   (pw_valid),
    .pw_ready   (pw_ready),
    .pw_power   (pw_power)
  );

  assign in_stall = !in_ready;

  // Tracker state update and result register.
  cfpst_track u_track (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .pw_valid           (pw_valid),
    .pw_ready           (pw_ready),
    .pw_power           (pw_power),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_duty_permille  (out_duty_permille),
    .out_measured_power (out_measured_power),
    .out_fine_mode      (out_fine_mode),
    .out_on_target      (out_on_target)
  );

endmodule
